@@ src/svmpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Servo mode press controller package
// Shared widths, event and mode codes, register map and reset values.
// ----------------------------------------------------------------------------
package svmpc_pkg;

    localparam int TimeW   = 32;
    localparam int PosW    = 16;
    localparam int PotW    = 12;
    localparam int CfgW    = 16;
    localparam int AddrW   = 5;
    localparam int ApbW    = 32;
    localparam int InDataW = 16;
    localparam int OutW    = 24;

    localparam logic [PotW-1:0] PotFull = 12'd4095;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_PRESS   = 2'd1,
        FUNC_RELEASE = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        MODE_HOLD = 2'd0,
        MODE_SCAN = 2'd1,
        MODE_KNOB = 2'd2
    } mode_t;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_PW_MIN        = 3'd0;
    localparam logic [2:0] REG_PW_MAX        = 3'd1;
    localparam logic [2:0] REG_DEBOUNCE      = 3'd2;
    localparam logic [2:0] REG_NORMAL_PRESS  = 3'd3;
    localparam logic [2:0] REG_LONG_PRESS    = 3'd4;
    localparam logic [2:0] REG_MANUAL_PERIOD = 3'd5;

    localparam logic [CfgW-1:0] PwMinRst        = 16'd500;
    localparam logic [CfgW-1:0] PwMaxRst        = 16'd2500;
    localparam logic [CfgW-1:0] DebounceRst     = 16'd20;
    localparam logic [CfgW-1:0] NormalPressRst  = 16'd1000;
    localparam logic [CfgW-1:0] LongPressRst    = 16'd2000;
    localparam logic [CfgW-1:0] ManualPeriodRst = 16'd200;

    // Result beat layout in m_tdata.
    localparam int OutModeLo = 16;
    localparam int OutLedBit = 18;
    localparam int OutTakBit = 19;

endpackage

@@ src/servo_mode_press_controller_core.sv @@
// ----------------------------------------------------------------------------
// Servo mode press controller core
// Picks sweep, freeze or manual servo mode from the button hold time and
// produces one pulse width result beat for every event beat.
// ----------------------------------------------------------------------------
//
// Channel   | Direction | Contents
// ----------+-----------+----------------------------------------------------
// s_*       | in        | event beat: tuser = func, tdata = pot_sample
// m_*       | out       | result beat: pulse_width, mode_now, led_on,
//           |           | edge_taken
// APB       | in / out  | six 16-bit registers at byte addresses 0..20
//
// Each event beat passes through the input register and then the result
// register before its result beat is presented. A new beat is accepted
// every cycle while results are taken; the input register keeps accepting
// while a result waits, so one stalled result still leaves room for one more
// event. The rate is set by the single combinational pass from the input
// register to the result register, whose longest path is the 12x16 multiply
// and the divide-by-4095 correction of manual mode.
// Reset is asynchronous and active low; it loads the register defaults and
// clears all timing and mode state.
// ----------------------------------------------------------------------------
module servo_mode_press_controller_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    // Event channel
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [svmpc_pkg::InDataW-1:0] s_tdata,  // [11:0] pot_sample, [15:12] zero
    input  logic [1:0]                   s_tuser,   // [1:0] func
    // Result channel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [svmpc_pkg::OutW-1:0]   m_tdata,   // [15:0] pulse_width, [17:16] mode_now,
                                                    // [18] led_on, [19] edge_taken, [23:20] zero
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [svmpc_pkg::AddrW-1:0]  paddr,
    input  logic [svmpc_pkg::ApbW-1:0]   pwdata,
    output logic [svmpc_pkg::ApbW-1:0]   prdata,
    output logic                         pready
);
    import svmpc_pkg::*;

    // Configuration registers.
    logic [CfgW-1:0] pw_min_reg;
    logic [CfgW-1:0] pw_max_reg;
    logic [CfgW-1:0] debounce_reg;
    logic [CfgW-1:0] normal_press_reg;
    logic [CfgW-1:0] long_press_reg;
    logic [CfgW-1:0] manual_period_reg;

    // Input register.
    logic            in_valid_reg;
    logic [1:0]      in_func_reg;
    logic [PotW-1:0] in_pot_reg;

    // Controller state.
    logic [TimeW-1:0] tick_count_reg,   tick_count_next;
    logic [TimeW-1:0] last_press_reg,   last_press_next;
    logic [TimeW-1:0] last_release_reg, last_release_next;
    logic [TimeW-1:0] hold_start_reg,   hold_start_next;
    mode_t            mode_reg,         mode_next;
    logic [PosW-1:0]  position_reg,     position_next;
    logic             sweep_down_reg,   sweep_down_next;
    logic [PosW-1:0]  compare_reg,      compare_next;
    logic             led_reg,          led_next;
    logic [CfgW-1:0]  manual_wait_reg,  manual_wait_next;
    logic             taken_next;

    // Result register.
    logic            out_valid_reg;
    logic [OutW-1:0] out_data_reg;

    logic            move;
    logic            cfg_write;
    logic [2:0]      cfg_index;

    // Manual-mode arithmetic.
    logic [PosW-1:0]  range;
    logic [27:0]      product;
    logic [28:0]      quot_sum;
    logic [16:0]      quot_est;
    logic [28:0]      quot_rem;
    logic [16:0]      quot;
    logic [PosW-1:0]  manual_pos;
    logic [PosW-1:0]  period_m1;
    logic [PosW-1:0]  sweep_step;
    logic [TimeW-1:0] since_press;
    logic [TimeW-1:0] since_release;
    logic [TimeW-1:0] held;

    // ------------------------------------------------------------------------
    // Handshake: the input register advances whenever the result register
    // is empty or its beat is being taken.
    // ------------------------------------------------------------------------
    assign move     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || move;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------------
    // Configuration port. Writes land on the access cycle; reads are direct.
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[AddrW-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_min_reg        <= PwMinRst;
            pw_max_reg        <= PwMaxRst;
            debounce_reg      <= DebounceRst;
            normal_press_reg  <= NormalPressRst;
            long_press_reg    <= LongPressRst;
            manual_period_reg <= ManualPeriodRst;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PW_MIN:        pw_min_reg        <= pwdata[CfgW-1:0];
                REG_PW_MAX:        pw_max_reg        <= pwdata[CfgW-1:0];
                REG_DEBOUNCE:      debounce_reg      <= pwdata[CfgW-1:0];
                REG_NORMAL_PRESS:  normal_press_reg  <= pwdata[CfgW-1:0];
                REG_LONG_PRESS:    long_press_reg    <= pwdata[CfgW-1:0];
                REG_MANUAL_PERIOD: manual_period_reg <= pwdata[CfgW-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_PW_MIN:        prdata = {{(ApbW-CfgW){1'b0}}, pw_min_reg};
            REG_PW_MAX:        prdata = {{(ApbW-CfgW){1'b0}}, pw_max_reg};
            REG_DEBOUNCE:      prdata = {{(ApbW-CfgW){1'b0}}, debounce_reg};
            REG_NORMAL_PRESS:  prdata = {{(ApbW-CfgW){1'b0}}, normal_press_reg};
            REG_LONG_PRESS:    prdata = {{(ApbW-CfgW){1'b0}}, long_press_reg};
            REG_MANUAL_PERIOD: prdata = {{(ApbW-CfgW){1'b0}}, manual_period_reg};
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Input register.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (move)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_func_reg <= s_tuser;
            in_pot_reg  <= s_tdata[PotW-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Manual mapping: min + pot * range / 4095. The quotient is estimated
    // from x/4096 + x/4096^2, which is never high and at most one low, and
    // then corrected with one compare on the remainder.
    // ------------------------------------------------------------------------
    assign range    = (pw_max_reg >= pw_min_reg) ? (pw_max_reg - pw_min_reg) : '0;
    assign product  = 28'(in_pot_reg) * 28'(range);
    assign quot_sum = 29'(product) + 29'(product >> 12);
    assign quot_est = quot_sum[28:12];
    assign quot_rem = 29'(product) - {quot_est[16:0], 12'b0} + 29'(quot_est);
    assign quot     = (quot_rem >= 29'(PotFull)) ? (quot_est + 17'd1) : quot_est;
    assign manual_pos = quot[PosW-1:0] + pw_min_reg;
    assign period_m1  = (manual_period_reg == '0) ? '0 : (manual_period_reg - 16'd1);

    assign sweep_step    = sweep_down_reg ? (position_reg - 16'd1) : (position_reg + 16'd1);
    assign since_press   = tick_count_reg - last_press_reg;
    assign since_release = tick_count_reg - last_release_reg;
    assign held          = tick_count_reg - hold_start_reg;

    // ------------------------------------------------------------------------
    // Event processing for the beat in the input register.
    // ------------------------------------------------------------------------
    always_comb
    begin
        tick_count_next   = tick_count_reg;
        last_press_next   = last_press_reg;
        last_release_next = last_release_reg;
        hold_start_next   = hold_start_reg;
        mode_next         = mode_reg;
        position_next     = position_reg;
        sweep_down_next   = sweep_down_reg;
        compare_next      = compare_reg;
        led_next          = led_reg;
        manual_wait_next  = manual_wait_reg;
        taken_next        = 1'b0;

        unique case (in_func_reg)
            FUNC_TICK:
            begin
                tick_count_next = tick_count_reg + 32'd1;
                if (mode_reg == MODE_SCAN)
                begin
                    // Drive the old position, then step and bounce.
                    compare_next = position_reg;
                    if (sweep_step >= pw_max_reg)
                    begin
                        position_next   = pw_max_reg;
                        sweep_down_next = 1'b1;
                    end
                    else if (sweep_step <= pw_min_reg)
                    begin
                        position_next   = pw_min_reg;
                        sweep_down_next = 1'b0;
                    end
                    else
                    begin
                        position_next = sweep_step;
                    end
                end
                else if (mode_reg == MODE_KNOB)
                begin
                    if (manual_wait_reg == '0)
                    begin
                        position_next    = manual_pos;
                        compare_next     = manual_pos;
                        manual_wait_next = period_m1;
                    end
                    else
                    begin
                        manual_wait_next = manual_wait_reg - 16'd1;
                    end
                end
            end
            FUNC_PRESS:
            begin
                if (since_press >= 32'(debounce_reg))
                begin
                    hold_start_next = tick_count_reg;
                    last_press_next = tick_count_reg;
                    taken_next      = 1'b1;
                end
            end
            FUNC_RELEASE:
            begin
                if (since_release >= 32'(debounce_reg))
                begin
                    if (held < 32'(normal_press_reg))
                    begin
                        mode_next = MODE_SCAN;
                        led_next  = 1'b1;
                    end
                    else if (held < 32'(long_press_reg))
                    begin
                        mode_next = MODE_HOLD;
                        led_next  = 1'b0;
                    end
                    else
                    begin
                        mode_next        = MODE_KNOB;
                        led_next         = 1'b0;
                        manual_wait_next = '0;
                    end
                    hold_start_next   = tick_count_reg;
                    last_release_next = tick_count_reg;
                    taken_next        = 1'b1;
                end
            end
            default:
            begin
                // The unused event code leaves everything as it is.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg   <= '0;
            last_press_reg   <= '0;
            last_release_reg <= '0;
            hold_start_reg   <= '0;
            mode_reg         <= MODE_HOLD;
            position_reg     <= PwMinRst;
            sweep_down_reg   <= 1'b0;
            compare_reg      <= PwMinRst;
            led_reg          <= 1'b0;
            manual_wait_reg  <= '0;
        end
        else if (move)
        begin
            tick_count_reg   <= tick_count_next;
            last_press_reg   <= last_press_next;
            last_release_reg <= last_release_next;
            hold_start_reg   <= hold_start_next;
            mode_reg         <= mode_next;
            position_reg     <= position_next;
            sweep_down_reg   <= sweep_down_next;
            compare_reg      <= compare_next;
            led_reg          <= led_next;
            manual_wait_reg  <= manual_wait_next;
        end
    end

    // ------------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_data_reg <= {4'b0, taken_next, led_next, mode_next, compare_next};
        end
    end

endmodule

@@ src/svmpc_chk.sv @@
// ----------------------------------------------------------------------------
// Servo mode press controller port checker
// Watches the stream ports of the core over time.
// ----------------------------------------------------------------------------
module svmpc_chk
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [svmpc_pkg::OutW-1:0] m_tdata
);
    import svmpc_pkg::*;

    // A stalled result beat stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // The event side only stalls when a result beat is held back downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("event channel stalled without a blocked result");

    // The LED is lit only in sweep mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[OutLedBit] |-> m_tdata[OutModeLo+1:OutModeLo] == MODE_SCAN)
        else $error("LED on outside sweep mode");

    // With the result register empty, the event side never stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("event channel stalled with an empty result register");

endmodule

bind servo_mode_press_controller_core svmpc_chk u_svmpc_chk (.*);
